// ----- rtl/reed_solomon_255_239_encoder_unit_defines.svh -----
// Assertion macros shared by the verification files of the RS(255,239) encoder.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef REED_SOLOMON_255_239_ENCODER_UNIT_DEFINES_SVH
`define REED_SOLOMON_255_239_ENCODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rse_pkg.sv -----
// Package of the RS(255,239) encoder: symbol types, generator coefficients
// and the GF(2^8) constant multiplier. No dependencies.
package rse_pkg;

    localparam int PARITY_SYMBOLS = 16;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = $clog2(PARITY_SYMBOLS + 1);

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [PARITY_SYMBOLS-1:0][SYM_W-1:0] t_par_vec;
    typedef logic [CNT_W-1:0] t_par_cnt;

    // Reduction term of the field polynomial x^8+x^7+x^2+x+1 without the x^8 bit.
    localparam t_sym FIELD_POLY_LOW = 8'h87;

    localparam t_sym MSG_LEN_RESET = 8'd239;

    // Generator coefficients g_0 .. g_15; index j multiplies into register j.
    localparam t_sym GEN_COEF [PARITY_SYMBOLS] = '{
        8'd165, 8'd105, 8'd27,  8'd159, 8'd104, 8'd152, 8'd101, 8'd76,
        8'd101, 8'd152, 8'd104, 8'd159, 8'd27,  8'd105, 8'd165, 8'd1
    };

    // Status of the parity drain as seen by the output stage.
    typedef struct packed {
        logic busy;
        logic last;
        t_sym sym;
    } t_drain_stat;

    // Shift-and-add multiply in GF(2^8). With a constant k this reduces to
    // a small XOR network.
    function automatic t_sym gf_mul(input t_sym a, input t_sym k);
        t_sym x;
        t_sym acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < SYM_W; i++) begin
            if (k[i]) begin
                acc = acc ^ x;
            end
            x = {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? FIELD_POLY_LOW : '0);
        end
        return acc;
    endfunction

endpackage

// ----- rtl/rse_lfsr.sv -----
// Parity LFSR and message byte counter of the RS(255,239) encoder.
// Depends on rse_pkg.
module rse_lfsr (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rse_pkg::t_sym     i_data,
    input  rse_pkg::t_sym     i_msg_len,
    output rse_pkg::t_par_vec o_next_parity,
    output logic              o_done
);
    import rse_pkg::*;

    t_par_vec r_reg;
    t_sym     r_count;
    t_par_vec n_reg;
    t_sym     fb;
    logic [SYM_W:0] taken;

    always_comb begin
        fb = r_reg[0] ^ i_data;
        for (int j = 0; j < PARITY_SYMBOLS - 1; j++) begin
            n_reg[j] = gf_mul(fb, GEN_COEF[j]) ^ r_reg[j+1];
        end
        n_reg[PARITY_SYMBOLS-1] = gf_mul(fb, GEN_COEF[PARITY_SYMBOLS-1]);
    end

    // A zero length behaves like one, since taken is never below one.
    assign taken         = {1'b0, r_count} + {{SYM_W{1'b0}}, 1'b1};
    assign o_done        = taken >= {1'b0, i_msg_len};
    assign o_next_parity = n_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            if (o_done) begin
                r_reg   <= '0;
                r_count <= '0;
            end else begin
                r_reg   <= n_reg;
                r_count <= taken[SYM_W-1:0];
            end
        end
    end

endmodule

// ----- rtl/rse_drain.sv -----
// Parity drain of the RS(255,239) encoder: holds a finished parity snapshot
// and hands it out one symbol at a time. Depends on rse_pkg.
module rse_drain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rse_pkg::t_par_vec   i_parity,
    input  logic                i_pop,
    output rse_pkg::t_drain_stat o_stat
);
    import rse_pkg::*;

    t_par_vec r_par;
    t_par_cnt r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= t_par_cnt'(PARITY_SYMBOLS);
        end else if (i_pop) begin
            r_left <= r_left - t_par_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_par <= i_parity;
        end else if (i_pop) begin
            r_par <= t_par_vec'({{SYM_W{1'b0}}, r_par[PARITY_SYMBOLS-1:1]});
        end
    end

    assign o_stat.busy = r_left != '0;
    assign o_stat.last = r_left == t_par_cnt'(1);
    assign o_stat.sym  = r_par[0];

endmodule

// ----- rtl/reed_solomon_255_239_encoder_unit.sv -----
// Top level of the systematic RS(255,239) encoder.
// Depends on rse_pkg, rse_lfsr and rse_drain.

// Systematic Reed-Solomon RS(255,239) encoder over GF(2^8), field polynomial
// x^8+x^7+x^2+x+1. Every message byte accepted on the input channel is echoed
// on the output channel with o_is_parity low. Once message_length bytes of a
// codeword have been taken (a length of zero acts as one, values above 239
// give longer codewords), the 16 parity bytes follow directly in order, all
// with o_is_parity high and o_last high on the sixteenth, and the encoder
// starts the next codeword from a cleared state. The LFSR update is a fixed
// XOR network between a one-entry skid register and the output register, so
// a byte per cycle is sustained within a codeword while i_stall stays low.
// At the codeword end the output register is busy with the parity bytes;
// during that time one input transaction is absorbed by the skid register
// and further ones see o_stall. o_stall comes from a register, so the input
// side never waits on i_stall combinationally. The length register resets
// to 239 and is written through the configuration channel, which is always
// ready; write it only while the encoder is idle.
module reed_solomon_255_239_encoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input channel
    input  logic          i_valid,
    output logic          o_stall,
    input  rse_pkg::t_sym i_data_byte,
    // Output channel
    output logic          o_valid,
    input  logic          i_stall,
    output rse_pkg::t_sym o_out_byte,
    output logic          o_is_parity,
    output logic          o_last,
    // Configuration channel: message length
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  rse_pkg::t_sym i_cfg_data
);
    import rse_pkg::*;

    // Configuration register.
    t_sym r_msg_len;

    // Skid register in front of the LFSR.
    logic r_skid_valid;
    t_sym r_skid_data;

    // Output register.
    logic r_out_valid;
    t_sym r_out_byte;
    logic r_out_parity;
    logic r_out_last;

    t_par_vec    next_parity;
    logic        cw_done;
    t_drain_stat drain;
    logic        out_free;
    logic        head_valid;
    t_sym        head_data;
    logic        step;
    logic        in_acc;
    logic        drain_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len <= MSG_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_msg_len <= i_cfg_data;
        end
    end

    // The skid entry, when present, is always older than the port.
    assign head_valid = r_skid_valid || i_valid;
    assign head_data  = r_skid_valid ? r_skid_data : i_data_byte;
    assign out_free   = !r_out_valid || !i_stall;

    // Parity has priority over the next message byte.
    assign step      = out_free && !drain.busy && head_valid;
    assign drain_pop = out_free && drain.busy;
    assign in_acc    = i_valid && !o_stall;
    assign o_stall   = r_skid_valid;

    rse_lfsr u_lfsr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_data        (head_data),
        .i_msg_len     (r_msg_len),
        .o_next_parity (next_parity),
        .o_done        (cw_done)
    );

    rse_drain u_drain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && cw_done),
        .i_parity (next_parity),
        .i_pop    (drain_pop),
        .o_stat   (drain)
    );

    // An input transaction that cannot be processed right away parks in the
    // skid register; a parked one leaves as soon as it is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (step) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && !step) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && in_acc && !step) begin
            r_skid_data <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= drain.busy || step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (drain.busy) begin
                r_out_byte   <= drain.sym;
                r_out_parity <= 1'b1;
                r_out_last   <= drain.last;
            end else begin
                r_out_byte   <= head_data;
                r_out_parity <= 1'b0;
                r_out_last   <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_parity = r_out_parity;
    assign o_last      = r_out_last;

endmodule

// ----- rtl/rse_checker.sv -----
// Port-level checker for the RS(255,239) encoder, bound to the top level.
// Depends on rse_pkg and reed_solomon_255_239_encoder_unit_defines.svh.
`include "reed_solomon_255_239_encoder_unit_defines.svh"

module rse_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input rse_pkg::t_sym o_out_byte,
    input logic          o_is_parity,
    input logic          o_last
);

    logic                      out_wait;
    logic                      par_more;
    logic [rse_pkg::SYM_W+1:0] out_word;

    assign out_wait = o_valid && i_stall;
    assign par_more = o_valid && !i_stall && o_is_parity && !o_last;
    assign out_word = {o_out_byte, o_is_parity, o_last};

    // The codeword marker only ever sits on a parity symbol.
    `RSE_ASSERT_SAME(a_last_is_parity, o_valid && o_last, o_is_parity, "last on a non-parity byte")

    // Parity symbols leave back to back until the last one.
    `RSE_ASSERT_NEXT(a_parity_run, par_more, o_valid && o_is_parity, "parity run broken")

    // A stalled output transaction holds its payload.
    `RSE_ASSERT_NEXT(a_out_hold, out_wait, o_valid && $stable(out_word), "held output changed")

endmodule

bind reed_solomon_255_239_encoder_unit rse_checker u_rse_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for reed_solomon_255_239_encoder_unit: a directed table,
// then random codewords, checked against a local RS(255,239) model or typed parity.
// Depends on rse_pkg and the encoder RTL.
module tb_top;

    import rse_pkg::t_sym;

    // Clock half period, reset length, and a run limit that still leaves several
    // times the slowest legal run.
    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 9;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          RAND_ITEMS   = 170;
    localparam int          TAIL_CYCLES  = 20;

    // Model constants. The field polynomial is x^8+x^7+x^2+x+1, and the
    // generator taps g_0..g_15 multiply into register j.
    localparam int   NPAR            = 16;
    localparam t_sym POLY_LOW        = 8'h87;
    localparam t_sym LEN_AFTER_RESET = 8'd239;
    localparam t_sym GEN_TAPS [NPAR] = '{
        8'd165, 8'd105, 8'd27,  8'd159, 8'd104, 8'd152, 8'd101, 8'd76,
        8'd101, 8'd152, 8'd104, 8'd159, 8'd27,  8'd105, 8'd165, 8'd1
    };

    // How the parity of a table row is checked. Rows marked zero or taps have
    // their parity typed in: a zero byte into a cleared encoder yields sixteen
    // zero parity bytes, and a single 01 byte yields the generator taps.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ZERO_PARITY,
        CHK_GEN_PARITY
    } t_chk;

    typedef enum logic {
        ROW_LEN,
        ROW_BYTE
    } t_row_op;

    typedef struct packed {
        t_row_op op;
        t_sym    val;
        t_chk    chk;
    } t_row;

    typedef struct packed {
        t_sym sym;
        logic par;
        logic lst;
    } t_out_sym;

    // Directed table. It starts at the reset length of 239 with three bytes,
    // then lowers the length to 3 in the middle of that codeword so parity
    // must come right after the next byte. A length of zero must act as one.
    localparam int NDIR = 24;
    localparam t_row DIRECTED [NDIR] = '{
        '{ROW_BYTE, 8'h00, CHK_MODEL},
        '{ROW_BYTE, 8'hFF, CHK_MODEL},
        '{ROW_BYTE, 8'h5A, CHK_MODEL},
        '{ROW_LEN,  8'd3,  CHK_MODEL},
        '{ROW_BYTE, 8'h81, CHK_MODEL},
        '{ROW_LEN,  8'd0,  CHK_MODEL},
        '{ROW_BYTE, 8'h00, CHK_ZERO_PARITY},
        '{ROW_BYTE, 8'h01, CHK_GEN_PARITY},
        '{ROW_BYTE, 8'hFF, CHK_MODEL},
        '{ROW_LEN,  8'd1,  CHK_MODEL},
        '{ROW_BYTE, 8'h80, CHK_MODEL},
        '{ROW_BYTE, 8'h01, CHK_GEN_PARITY},
        '{ROW_LEN,  8'd2,  CHK_MODEL},
        '{ROW_BYTE, 8'h00, CHK_MODEL},
        '{ROW_BYTE, 8'h00, CHK_ZERO_PARITY},
        '{ROW_BYTE, 8'h7F, CHK_MODEL},
        '{ROW_BYTE, 8'hFE, CHK_MODEL},
        '{ROW_LEN,  8'd5,  CHK_MODEL},
        '{ROW_BYTE, 8'h01, CHK_MODEL},
        '{ROW_BYTE, 8'h02, CHK_MODEL},
        '{ROW_BYTE, 8'h04, CHK_MODEL},
        '{ROW_BYTE, 8'h08, CHK_MODEL},
        '{ROW_BYTE, 8'h10, CHK_MODEL},
        '{ROW_LEN,  8'd17, CHK_MODEL}
    };

    // Every input of the encoder has a known value from time zero.
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_valid     = 1'b0;
    t_sym i_data_byte = '0;
    logic i_stall     = 1'b0;
    logic i_cfg_valid = 1'b0;
    t_sym i_cfg_data  = '0;
    logic o_stall;
    logic o_valid;
    t_sym o_out_byte;
    logic o_is_parity;
    logic o_last;
    logic o_cfg_ready;

    // Check mode that travels with the byte on the input channel, so the
    // monitor sees it together with the payload of the same transaction.
    t_chk data_chk = CHK_MODEL;

    // Output stall control; stall_on is driven with the stimulus.
    logic stall_on   = 1'b0;
    int   stall_left = 0;
    bit   gaps_on    = 1'b0;

    // Model state: the parity LFSR, the message byte count and the length.
    t_sym lfsr_q [NPAR] = '{default: '0};
    t_sym byte_cnt      = '0;
    t_sym msg_len       = LEN_AFTER_RESET;

    t_out_sym    pending_syms[$];
    int          errors    = 0;
    int unsigned cycle_cnt = 0;

    reed_solomon_255_239_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_is_parity (o_is_parity),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // GF(2^8) product by Horner's rule, most significant bit of b first.
    function automatic t_sym gf_times(input t_sym a, input t_sym b);
        t_sym acc;
        acc = '0;
        for (int i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? POLY_LOW : 8'h00);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // Shifts one message byte into the LFSR and queues what the encoder must
    // produce for it: the echo, and the sixteen parity bytes when the byte
    // completes the codeword. The count compare is unsigned, so a length of
    // zero closes a codeword after every byte.
    function automatic void encode_symbol(input t_sym d, input t_chk chk);
        t_sym        fb;
        int unsigned taken;
        t_out_sym    r;
        fb = lfsr_q[0] ^ d;
        for (int j = 0; j < NPAR - 1; j++) begin
            lfsr_q[j] = gf_times(GEN_TAPS[j], fb) ^ lfsr_q[j+1];
        end
        lfsr_q[NPAR-1] = gf_times(GEN_TAPS[NPAR-1], fb);
        r = '{sym: d, par: 1'b0, lst: 1'b0};
        pending_syms.push_back(r);
        taken = byte_cnt + 1;
        if (taken < msg_len) begin
            byte_cnt = t_sym'(taken);
        end else begin
            for (int j = 0; j < NPAR; j++) begin
                r.sym = lfsr_q[j];
                if (chk == CHK_ZERO_PARITY) begin
                    r.sym = 8'h00;
                end else if (chk == CHK_GEN_PARITY) begin
                    r.sym = GEN_TAPS[j];
                end
                r.par = 1'b1;
                r.lst = (j == NPAR - 1);
                pending_syms.push_back(r);
                lfsr_q[j] = '0;
            end
            byte_cnt = '0;
        end
    endfunction

    // One process watches all three channels. Inputs and the length write
    // are folded into the model before outputs are compared, so the order
    // holds even for a result that leaves in the same cycle as its input.
    always @(posedge i_clk) begin
        t_out_sym e;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                msg_len = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                encode_symbol(i_data_byte, data_chk);
            end
            if (o_valid && !i_stall) begin
                if (pending_syms.size() == 0) begin
                    $display("%0t: unexpected output: %02h is_parity %0b last %0b",
                             $time, o_out_byte, o_is_parity, o_last);
                    errors++;
                end else begin
                    e = pending_syms.pop_front();
                    if (o_out_byte !== e.sym) begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, e.sym, o_out_byte);
                        errors++;
                    end
                    if (o_is_parity !== e.par) begin
                        $display("%0t: is_parity mismatch: expected %0b, actual %0b",
                                 $time, e.par, o_is_parity);
                        errors++;
                    end
                    if (o_last !== e.lst) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, e.lst, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Output back-pressure in random bursts while enabled.
    always @(posedge i_clk) begin
        if (!stall_on) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Biased byte source: the two extremes come up often, so the all-zero
    // and all-one cases are hit within most codewords.
    function automatic t_sym pick_symbol();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_sym'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one byte and returns at the edge where it is taken. Valid stays
    // high into the next call unless a gap is inserted there.
    task automatic send_byte(input t_sym d, input t_chk chk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        data_chk    <= chk;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // Writes the message length once the encoder has delivered everything.
    // The first edge lets the last input transaction reach the model queue.
    task automatic write_length(input t_sym len);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_syms.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Run limit: a hang or a lost result ends here.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[reed_solomon_255_239_encoder_unit] ERROR");
        $finish;
    end

    initial begin
        int   rand_items;
        int   words;
        int   span;
        t_sym len;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: no idling on either side.
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].op == ROW_LEN) begin
                write_length(DIRECTED[i].val);
            end else begin
                send_byte(DIRECTED[i].val, DIRECTED[i].chk);
            end
        end

        // Random part. Each phase picks a length, turns idling on or off on
        // each side, and sends whole codewords, sometimes followed by a
        // partial one that the next length change then cuts short or
        // stretches.
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 8'd0;
                1: len = 8'd1;
                default: len = t_sym'($urandom_range(2, 24));
            endcase
            write_length(len);
            gaps_on  = ($urandom_range(0, 2) != 0);
            stall_on <= ($urandom_range(0, 2) != 0);
            span  = (len == 0) ? 1 : len;
            words = $urandom_range(1, 3);
            for (int w = 0; w < words; w++) begin
                for (int k = 0; k < span; k++) begin
                    send_byte(pick_symbol(), CHK_MODEL);
                    rand_items++;
                end
            end
            if (span > 2 && $urandom_range(0, 3) == 0) begin
                for (int k = $urandom_range(1, span - 1); k > 0; k--) begin
                    send_byte(pick_symbol(), CHK_MODEL);
                    rand_items++;
                end
            end
        end

        // Closing stretch at full rate: no gaps and no back-pressure.
        gaps_on  = 1'b0;
        stall_on <= 1'b0;
        len = t_sym'($urandom_range(2, 20));
        write_length(len);
        for (int k = 0; k < 3 * len; k++) begin
            send_byte(pick_symbol(), CHK_MODEL);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_syms.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("[reed_solomon_255_239_encoder_unit] OK");
        end else begin
            $display("[reed_solomon_255_239_encoder_unit] ERROR");
        end
        $finish;
    end

endmodule
